@@ rtl/core/kvid_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package kvid_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned IdW    = 32;
  localparam int unsigned AccW   = 64;
  localparam int unsigned DigitW = 4;
  localparam int unsigned PosW   = 4;

  localparam logic [PosW-1:0] TargetLen = PosW'(12);

  localparam logic [ByteW-1:0] CharQuote = 8'h22;
  localparam logic [ByteW-1:0] CharZero  = 8'h30;
  localparam logic [ByteW-1:0] CharNine  = 8'h39;
  localparam logic [ByteW-1:0] CharSpace = 8'h20;
  localparam logic [ByteW-1:0] CharTab   = 8'h09;
  localparam logic [ByteW-1:0] CharCr    = 8'h0d;
  localparam logic [ByteW-1:0] CharLf    = 8'h0a;

  typedef struct packed {
    logic [ByteW-1:0] text_byte;
    logic             is_final;
  } kvid_in_t;

  typedef struct packed {
    logic [IdW-1:0] app_id;
    logic           hit;
    logic           done_res;
  } kvid_out_t;

  typedef struct packed {
    logic      emit;
    kvid_out_t item;
  } kvid_res_t;

  // "cloudenabled"
  function automatic logic [ByteW-1:0] target_char(input logic [PosW-1:0] pos);
    logic [ByteW-1:0] c;
    case (pos)
      4'd0:    c = 8'h63;
      4'd1:    c = 8'h6c;
      4'd2:    c = 8'h6f;
      4'd3:    c = 8'h75;
      4'd4:    c = 8'h64;
      4'd5:    c = 8'h65;
      4'd6:    c = 8'h6e;
      4'd7:    c = 8'h61;
      4'd8:    c = 8'h62;
      4'd9:    c = 8'h6c;
      4'd10:   c = 8'h65;
      4'd11:   c = 8'h64;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/keyvalue_text_disabled_id_scanner.sv @@
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake                 payload
// in        input      in_valid_i / in_stall_o    in_data_i  (text_byte, is_final)
// out       output     out_valid_o / out_stall_i  out_data_o (app_id, hit, done_res)
//
// one byte per cycle sustained while the output does not stall; an accepted byte goes
// into the input register, then through the scan logic into the result register
// results come only on a disabled-id hit and on the final byte
// reset clears the scan state and both valid flags
// a stalled output holds its item; the input stalls only while both registers are full
// and the output is stalled

module keyvalue_text_disabled_id_scanner (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire kvid_pkg::kvid_in_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output kvid_pkg::kvid_out_t      out_data_o
);

  logic                s1_valid_q, s1_valid_d;
  kvid_pkg::kvid_in_t  s1_data_q;
  logic                out_valid_q, out_valid_d;
  kvid_pkg::kvid_out_t out_data_q;

  logic                can_take;
  logic                step;
  logic                load;
  kvid_pkg::kvid_res_t res;

  assign can_take    = !out_valid_q || !out_stall_i;
  assign step        = s1_valid_q && can_take;
  assign in_stall_o  = s1_valid_q && !can_take;
  assign load        = in_valid_i && !in_stall_o;
  assign s1_valid_d  = load || (s1_valid_q && !step);
  assign out_valid_d = (step && res.emit) || (out_valid_q && out_stall_i);

  kvid_scan_core u_scan_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (s1_data_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      s1_data_q <= in_data_i;
    end
    if (step && res.emit) begin
      out_data_q <= res.item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_hit_nonzero_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.hit |-> out_data_o.app_id != '0)
    else $error("hit item carries a zero id");

  a_miss_is_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.hit |-> out_data_o.done_res && out_data_o.app_id == '0)
    else $error("item without hit that is not the final one");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while output can drain");

  a_step_empties_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && !load |=> !s1_valid_q)
    else $error("input register not emptied after its item moved on");

endmodule

`default_nettype wire

@@ rtl/core/kvid_digit_acc.sv @@
`timescale 1ns / 1ps
`default_nettype none

module kvid_digit_acc (
  input  wire logic [kvid_pkg::AccW-1:0]   acc_i,
  input  wire logic [kvid_pkg::DigitW-1:0] digit_i,
  output logic      [kvid_pkg::AccW-1:0]   acc_o
);

  localparam int unsigned SumW = kvid_pkg::AccW + 4;

  logic [SumW-1:0] acc_ext;
  logic [SumW-1:0] sum;

  // acc * 10 + digit, saturating
  assign acc_ext = {4'b0, acc_i};
  assign sum     = (acc_ext << 3) + (acc_ext << 1) + SumW'(digit_i);
  assign acc_o   = (sum[SumW-1:kvid_pkg::AccW] != 4'b0) ? {kvid_pkg::AccW{1'b1}}
                                                         : sum[kvid_pkg::AccW-1:0];

endmodule

`default_nettype wire

@@ rtl/core/kvid_scan_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

module kvid_scan_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               step_i,
  input  wire kvid_pkg::kvid_in_t item_i,
  output kvid_pkg::kvid_res_t     res_o
);

  localparam logic [1:0] PhOut = 2'd0;
  localparam logic [1:0] PhKey = 2'd1;
  localparam logic [1:0] PhGap = 2'd2;
  localparam logic [1:0] PhVal = 2'd3;

  localparam logic [1:0] VmEmpty = 2'd0;
  localparam logic [1:0] VmZero  = 2'd1;
  localparam logic [1:0] VmOther = 2'd2;

  logic [1:0]                  phase_q, phase_d;
  logic [kvid_pkg::PosW-1:0]   pos_q, pos_d;
  logic                        mism_q, mism_d;
  logic                        alldig_q, alldig_d;
  logic                        nonempty_q, nonempty_d;
  logic [kvid_pkg::AccW-1:0]   acc_q, acc_d;
  logic [1:0]                  vm_q, vm_d;
  logic [kvid_pkg::IdW-1:0]    block_q, block_d;

  logic [kvid_pkg::AccW-1:0]   acc_next;
  logic [kvid_pkg::ByteW-1:0]  b;
  logic                        is_quote;
  logic                        is_digit;
  logic                        is_space;
  logic                        hit;
  logic [kvid_pkg::IdW-1:0]    id;

  function automatic logic pair_hit(input logic mism, input logic [kvid_pkg::PosW-1:0] pos,
                                    input logic [1:0] vm, input logic [kvid_pkg::IdW-1:0] blk);
    return !mism && (pos == kvid_pkg::TargetLen) && (vm == VmZero) && (blk != '0);
  endfunction

  assign b        = item_i.text_byte;
  assign is_quote = (b == kvid_pkg::CharQuote);
  assign is_digit = (b >= kvid_pkg::CharZero) && (b <= kvid_pkg::CharNine);
  assign is_space = (b == kvid_pkg::CharSpace) || (b == kvid_pkg::CharTab) ||
                    (b == kvid_pkg::CharCr) || (b == kvid_pkg::CharLf);

  kvid_digit_acc u_digit_acc (
    .acc_i   (acc_q),
    .digit_i (b[kvid_pkg::DigitW-1:0]),
    .acc_o   (acc_next)
  );

  always_comb begin
    phase_d    = phase_q;
    pos_d      = pos_q;
    mism_d     = mism_q;
    alldig_d   = alldig_q;
    nonempty_d = nonempty_q;
    acc_d      = acc_q;
    vm_d       = vm_q;
    block_d    = block_q;
    hit        = 1'b0;

    case (phase_q)
      PhOut: begin
        if (is_quote) begin
          pos_d      = '0;
          mism_d     = 1'b0;
          alldig_d   = 1'b1;
          nonempty_d = 1'b0;
          acc_d      = '0;
          phase_d    = PhKey;
        end
      end
      PhKey: begin
        if (is_quote) begin
          phase_d = PhGap;
        end else begin
          nonempty_d = 1'b1;
          if (mism_q || (pos_q >= kvid_pkg::TargetLen)) begin
            mism_d = 1'b1;
          end else if (b == kvid_pkg::target_char(pos_q)) begin
            pos_d = pos_q + 1'b1;
          end else begin
            mism_d = 1'b1;
          end
          if (is_digit) begin
            acc_d = acc_next;
          end else begin
            alldig_d = 1'b0;
          end
        end
      end
      PhGap: begin
        if (is_quote) begin
          vm_d    = VmEmpty;
          phase_d = PhVal;
        end else if (!is_space) begin
          if (nonempty_q && alldig_q) begin
            block_d = acc_q[kvid_pkg::IdW-1:0];
          end
          phase_d = PhOut;
        end
      end
      default: begin
        if (is_quote) begin
          hit     = pair_hit(mism_q, pos_q, vm_q, block_q);
          phase_d = PhOut;
        end else if ((vm_q == VmEmpty) && (b == kvid_pkg::CharZero)) begin
          vm_d = VmZero;
        end else begin
          vm_d = VmOther;
        end
      end
    endcase

    // end of text: close open tokens, then back to reset state
    if (item_i.is_final) begin
      if (phase_d == PhVal) begin
        hit = pair_hit(mism_d, pos_d, vm_d, block_d);
      end else if ((phase_d == PhKey) || (phase_d == PhGap)) begin
        if (nonempty_d && alldig_d) begin
          block_d = acc_d[kvid_pkg::IdW-1:0];
        end
      end
    end

    id = block_d;

    if (item_i.is_final) begin
      phase_d    = PhOut;
      pos_d      = '0;
      mism_d     = 1'b0;
      alldig_d   = 1'b1;
      nonempty_d = 1'b0;
      acc_d      = '0;
      vm_d       = VmEmpty;
      block_d    = '0;
    end

    res_o.emit          = hit || item_i.is_final;
    res_o.item.app_id   = hit ? id : '0;
    res_o.item.hit      = hit;
    res_o.item.done_res = item_i.is_final;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhOut;
      pos_q      <= '0;
      mism_q     <= 1'b0;
      alldig_q   <= 1'b1;
      nonempty_q <= 1'b0;
      acc_q      <= '0;
      vm_q       <= VmEmpty;
      block_q    <= '0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      pos_q      <= pos_d;
      mism_q     <= mism_d;
      alldig_q   <= alldig_d;
      nonempty_q <= nonempty_d;
      acc_q      <= acc_d;
      vm_q       <= vm_d;
      block_q    <= block_d;
    end
  end

endmodule

`default_nettype wire
